FILE: hw/rtl/ple_pkg.sv
// Shared request and status codes and fixed field widths for the positional list engine.
`default_nettype none

package ple_pkg;

    localparam int FIELD_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_INS_AT    = 3'd2,
        MODE_DEL_FRONT = 3'd3,
        MODE_DEL_BACK  = 3'd4,
        MODE_DEL_AT    = 3'd5,
        MODE_DUMP      = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ple_store.sv
// Simple dual-port list storage: one write and one registered read per cycle.
`default_nettype none

module ple_store #(
    parameter int DEPTH      = 32,
    parameter int VALUE_BITS = 32,
    localparam int AW        = $clog2(DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [VALUE_BITS-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [VALUE_BITS-1:0] rd_data
);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data held until the next enabled read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: request sequencer, count and result register.
//
// The engine holds an ordered list of up to DEPTH values packed from entry 0 (the front)
// of a small storage array, plus an element count. Each input transaction inserts (front,
// back or 1-based position), deletes (front, back or position), or dumps the list. One
// transaction is worked on at a time and s_ready is low while it is in progress. Inserts
// and deletes move the stored entries one at a time through the storage array's single
// read and single write port: each moved entry is read, then written back one place over.
// An insert then writes the new value into its slot; a dump reads and then presents each
// element, holding while the result channel stalls. A non-dump transaction returns one result
// transaction with the status and the count afterwards, element zero and last set. A dump
// returns one result per element, front first, last on the final one; an empty dump returns
// one result with the empty status. A finished result sits in an output register, so the
// next input transaction is taken while it waits. The storage needs no clearing after
// reset: only entries below the count are ever read. Stored values keep the low VALUE_BITS
// bits of s_value; m_element is the stored value zero-extended or cut to 32 bits, and
// m_element_count carries the low six bits of the count.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic        [MODE_W-1:0]   s_mode,
    input  wire logic signed [FIELD_W-1:0]  s_value,
    input  wire logic        [POS_W-1:0]    s_position,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic             [STATUS_W-1:0] m_status,
    output logic signed      [FIELD_W-1:0]  m_element,
    output logic             [COUNT_W-1:0]  m_element_count,
    output logic                            m_last
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PCW = POS_W + 1;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SHIFT_RD = 7'b0000010,
        S_SHIFT_WR = 7'b0000100,
        S_PUT      = 7'b0001000,
        S_DUMP_RD  = 7'b0010000,
        S_DUMP_OUT = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    // sequencer state
    state_t                state_reg,  state_next;
    logic [CW-1:0]         count_reg,  count_next;
    logic [AW-1:0]         ptr_reg,    ptr_next;
    logic [AW-1:0]         idx_reg,    idx_next;
    logic                  ins_reg,    ins_next;
    status_t               status_reg, status_next;
    logic [VALUE_BITS-1:0] val_reg,    val_next;

    // result register
    logic                  m_valid_reg,   m_valid_next;
    status_t               m_status_reg,  m_status_next;
    logic [FIELD_W-1:0]    m_element_reg, m_element_next;
    logic [COUNT_W-1:0]    m_count_reg,   m_count_next;
    logic                  m_last_reg,    m_last_next;

    // storage port signals
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] rd_data;

    // request decode
    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    status_t               out_status;
    logic [FIELD_W-1:0]    out_element;
    logic                  out_last;
    logic [PCW-1:0]        pos_ext;
    logic [PCW-1:0]        cnt_ext;
    logic [POS_W-1:0]      pos_m1;
    logic                  list_full;
    logic                  list_empty;
    logic [AW-1:0]         tgt_idx;
    logic                  dump_last;

    ple_store #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (state_reg == S_PUT ? val_reg : rd_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign pos_ext    = {1'b0, s_position};
    assign cnt_ext    = PCW'(count_reg);
    assign pos_m1     = s_position - POS_W'(1);
    assign list_full  = (count_reg == CW'(DEPTH));
    assign list_empty = (count_reg == '0);
    assign dump_last  = ((CW'(ptr_reg) + CW'(1)) == count_reg);

    // 0-based target of the request; only used once the checks pass
    always_comb begin
        unique case (s_mode)
            MODE_INS_BACK:           tgt_idx = AW'(count_reg);
            MODE_DEL_BACK:           tgt_idx = AW'(count_reg - CW'(1));
            MODE_INS_AT, MODE_DEL_AT: tgt_idx = AW'(pos_m1);
            default:                 tgt_idx = '0;
        endcase
    end

    // storage addressing: shifts read the neighbour, dumps walk from the front
    always_comb begin
        rd_en   = (state_reg == S_SHIFT_RD) || (state_reg == S_DUMP_RD);
        rd_addr = ptr_reg;
        if (state_reg == S_SHIFT_RD) begin
            rd_addr = ins_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
        end
        wr_en   = (state_reg == S_SHIFT_WR) || (state_reg == S_PUT);
        wr_addr = (state_reg == S_PUT) ? idx_reg : ptr_reg;
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        ins_next    = ins_reg;
        status_next = status_reg;
        val_next    = val_reg;
        out_load    = 1'b0;
        out_status  = ST_OK;
        out_element = '0;
        out_last    = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    status_next = ST_OK;
                    val_next    = VALUE_BITS'($unsigned(s_value));
                    idx_next    = tgt_idx;
                    unique case (s_mode)
                        MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
                            ins_next = 1'b1;
                            ptr_next = AW'(count_reg);
                            if (s_mode == MODE_INS_AT &&
                                (s_position == '0 || pos_ext > cnt_ext + PCW'(1))) begin
                                status_next = ST_BADPOS;
                                state_next  = S_RESP;
                            end else if (list_full) begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end else if (CW'(tgt_idx) == count_reg) begin
                                state_next = S_PUT;
                            end else begin
                                state_next = S_SHIFT_RD;
                            end
                        end
                        MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
                            ins_next = 1'b0;
                            ptr_next = tgt_idx;
                            if (list_empty) begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end else if (s_mode == MODE_DEL_AT &&
                                         (s_position == '0 || pos_ext > cnt_ext)) begin
                                status_next = ST_BADPOS;
                                state_next  = S_RESP;
                            end else if ((CW'(tgt_idx) + CW'(1)) == count_reg) begin
                                // tail entry: nothing to move up
                                count_next = count_reg - CW'(1);
                                state_next = S_RESP;
                            end else begin
                                state_next = S_SHIFT_RD;
                            end
                        end
                        MODE_DUMP: begin
                            ptr_next = '0;
                            if (list_empty) begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default: begin
                            // unused code: plain ok response
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SHIFT_RD: begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                if (ins_reg) begin
                    ptr_next   = ptr_reg - AW'(1);
                    state_next = ((ptr_reg - AW'(1)) == idx_reg) ? S_PUT : S_SHIFT_RD;
                end else begin
                    ptr_next = ptr_reg + AW'(1);
                    if ((CW'(ptr_reg) + CW'(2)) == count_reg) begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RESP;
                    end else begin
                        state_next = S_SHIFT_RD;
                    end
                end
            end
            S_PUT: begin
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end
            S_DUMP_RD: begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_element = FIELD_W'(rd_data);
                    out_last    = dump_last;
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end else begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = status_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register next values
    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_element_next = m_element_reg;
        m_count_next   = m_count_reg;
        m_last_next    = m_last_reg;
        if (out_load) begin
            m_valid_next   = 1'b1;
            m_status_next  = out_status;
            m_element_next = out_element;
            m_count_next   = COUNT_W'(count_reg);
            m_last_next    = out_last;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        idx_reg       <= idx_next;
        ins_reg       <= ins_next;
        status_reg    <= status_next;
        val_reg       <= val_next;
        m_status_reg  <= m_status_next;
        m_element_reg <= m_element_next;
        m_count_reg   <= m_count_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_element       = $signed(m_element_reg);
    assign m_element_count = m_count_reg;
    assign m_last          = m_last_reg;

    // count never runs past the storage
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond depth");

    // an insert shift always stays above its target slot
    a_ins_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT_WR && ins_reg) |-> (ptr_reg > idx_reg))
        else $error("insert shift passed its target");

    // entries move only while the count is unchanged
    a_shift_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT_RD) |=> $stable(count_reg))
        else $error("count changed mid shift");

    // failed requests give a single zero-element result
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_element_reg == '0 && m_last_reg))
        else $error("error result carries element data");

    // a new result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("result overwritten before hand-off");

endmodule

`default_nettype wire
